>>> rtl/scpm_pkg.sv
// Shared types and constants for the stereo channel pan mixer.
// Used by the register block, the controller, the datapath and the top level.
// No dependencies.
package scpm_pkg;

    localparam int SCPM_NUM_CHANNELS = 8;
    localparam int CFG_ADDR_W        = 6;
    localparam int CFG_DATA_W        = 64;
    localparam int CHAN_W            = 3;
    localparam int SMP_W             = 16;
    localparam int ACC_W             = 24;

    // register indexes, byte address is 8 * index
    localparam logic [2:0] REG_VOLUMES = 3'd0;
    localparam logic [2:0] REG_PANS    = 3'd1;
    localparam logic [2:0] REG_ENABLE  = 3'd2;
    localparam logic [2:0] REG_MUTE    = 3'd3;
    localparam logic [2:0] REG_STEREO  = 3'd4;

    localparam logic [63:0] VOLUMES_RESET = 64'h8080_8080_8080_8080;

    // operand selection of the shared multiplier
    localparam logic [1:0] MUL_VOL_GL = 2'd0;
    localparam logic [1:0] MUL_VOL_GR = 2'd1;
    localparam logic [1:0] MUL_SMP_L  = 2'd2;
    localparam logic [1:0] MUL_SMP_R  = 2'd3;

    typedef struct packed {
        logic [63:0] volumes;
        logic [63:0] pans;
        logic [7:0]  enable;
        logic [7:0]  mute;
        logic [7:0]  stereo;
    } t_cfg;

    typedef struct packed {
        logic       load_item;
        logic [1:0] mul_sel;
        logic       save_vgl;
        logic       save_vgr;
        logic       acc_left;
        logic       acc_right;
        logic       emit;
    } t_dp_cmd;

    typedef struct packed {
        logic frame_end;
        logic out_free;
    } t_dp_status;

endpackage

>>> rtl/scpm_regs.sv
// APB-style configuration registers of the pan mixer: volumes, pans and masks.
// Depends on scpm_pkg.
module scpm_regs
    import scpm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_VOLUMES: n_cfg.volumes = pwdata;
                REG_PANS:    n_cfg.pans    = pwdata;
                REG_ENABLE:  n_cfg.enable  = pwdata[7:0];
                REG_MUTE:    n_cfg.mute    = pwdata[7:0];
                REG_STEREO:  n_cfg.stereo  = pwdata[7:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.volumes <= VOLUMES_RESET;
            r_cfg.pans    <= '0;
            r_cfg.enable  <= '0;
            r_cfg.mute    <= '0;
            r_cfg.stereo  <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_VOLUMES: prdata = r_cfg.volumes;
            REG_PANS:    prdata = r_cfg.pans;
            REG_ENABLE:  prdata = {56'd0, r_cfg.enable};
            REG_MUTE:    prdata = {56'd0, r_cfg.mute};
            REG_STEREO:  prdata = {56'd0, r_cfg.stereo};
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/scpm_ctrl.sv
// Sequencer of the pan mixer: steps the shared multiplier through its four
// products per item and schedules accumulation and result output. Depends on scpm_pkg.
module scpm_ctrl
    import scpm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_VG_L  = 3'd1;
    localparam logic [2:0] S_VG_R  = 3'd2;
    localparam logic [2:0] S_MUL_L = 3'd3;
    localparam logic [2:0] S_MUL_R = 3'd4;
    localparam logic [2:0] S_ACC_R = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       ready;

    always_comb begin
        n_state = r_state;
        ready   = 1'b0;
        o_cmd   = '0;
        o_cmd.mul_sel = MUL_VOL_GL;
        unique case (r_state)
            S_IDLE: begin
                ready = 1'b1;
            end
            S_VG_L: begin
                o_cmd.mul_sel = MUL_VOL_GL;
                n_state = S_VG_R;
            end
            S_VG_R: begin
                o_cmd.mul_sel  = MUL_VOL_GR;
                o_cmd.save_vgl = 1'b1;
                n_state = S_MUL_L;
            end
            S_MUL_L: begin
                o_cmd.mul_sel  = MUL_SMP_L;
                o_cmd.save_vgr = 1'b1;
                n_state = S_MUL_R;
            end
            S_MUL_R: begin
                o_cmd.mul_sel  = MUL_SMP_R;
                o_cmd.acc_left = 1'b1;
                n_state = S_ACC_R;
            end
            S_ACC_R: begin
                o_cmd.acc_right = 1'b1;
                if (i_status.frame_end) begin
                    n_state = S_EMIT;
                end else begin
                    ready   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                // hold until the output register can take the frame
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    ready      = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.load_item = ready && i_valid;
        if (ready && i_valid) begin
            n_state = S_VG_L;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = !ready;

endmodule

>>> rtl/scpm_dp.sv
// Datapath of the pan mixer: item capture, gain setup, shared multiplier,
// rounding, saturating accumulators and the output register. Depends on scpm_pkg.
module scpm_dp
    import scpm_pkg::*;
#(
    parameter int NUM_CHANNELS = SCPM_NUM_CHANNELS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cfg                    i_cfg,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_status,
    input  logic [CHAN_W-1:0]       i_chan_index,
    input  logic signed [SMP_W-1:0] i_left_in,
    input  logic signed [SMP_W-1:0] i_right_in,
    input  logic                    i_frame_end,
    input  logic                    i_out_stall,
    output logic                    o_out_valid,
    output logic signed [SMP_W-1:0] o_left_out,
    output logic signed [SMP_W-1:0] o_right_out,
    output logic                    o_clipped
);

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] OUT_MIN = -ACC_W'(32768);

    // captured item
    logic signed [SMP_W-1:0] r_left;
    logic signed [SMP_W-1:0] r_rs;
    logic                    r_active;
    logic                    r_end;
    logic [7:0]              r_vol;
    logic [7:0]              r_gl;
    logic [7:0]              r_gr;
    logic [14:0]             r_vgl;
    logic [14:0]             r_vgr;
    logic signed [32:0]      r_prod;

    logic signed [ACC_W-1:0] r_left_sum;
    logic signed [ACC_W-1:0] r_right_sum;
    logic signed [ACC_W-1:0] n_left_sum;
    logic signed [ACC_W-1:0] n_right_sum;

    logic                    r_out_valid;
    logic signed [SMP_W-1:0] r_left_out;
    logic signed [SMP_W-1:0] r_right_out;
    logic                    r_clipped;

    logic [7:0]        vol_raw;
    logic signed [7:0] pan_raw;
    logic signed [7:0] pan_c;
    logic [7:0]        vol_c;
    logic signed [8:0] gl_s;
    logic signed [8:0] gr_s;
    logic              act;

    logic signed [16:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [32:0] rnd;
    logic signed [17:0] contrib;
    logic signed [ACC_W:0] acc_in;
    logic signed [ACC_W:0] acc_sum;
    logic signed [ACC_W-1:0] acc_sat;

    logic signed [SMP_W-1:0] l_sat;
    logic signed [SMP_W-1:0] r_sat;
    logic                    l_clip;
    logic                    r_clip;
    logic                    out_free;

    // per-channel gain setup at capture
    always_comb begin
        vol_raw = i_cfg.volumes[{i_chan_index, 3'b000} +: 8];
        pan_raw = $signed(i_cfg.pans[{i_chan_index, 3'b000} +: 8]);
        vol_c   = (vol_raw > 8'd128) ? 8'd128 : vol_raw;
        if (pan_raw > 8'sd64) begin
            pan_c = 8'sd64;
        end else if (pan_raw < -8'sd64) begin
            pan_c = -8'sd64;
        end else begin
            pan_c = pan_raw;
        end
        gl_s = 9'sd64 - 9'(pan_c);
        gr_s = 9'sd64 + 9'(pan_c);
        act  = ({1'b0, i_chan_index} < (CHAN_W+1)'(NUM_CHANNELS))
               && i_cfg.enable[i_chan_index] && !i_cfg.mute[i_chan_index];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_left <= i_left_in;
            r_rs   <= i_cfg.stereo[i_chan_index] ? i_right_in : i_left_in;
            r_end  <= i_frame_end;
            r_vol  <= vol_c;
            r_gl   <= gl_s[7:0];
            r_gr   <= gr_s[7:0];
        end
        if (i_cmd.save_vgl) begin
            r_vgl <= r_prod[14:0];
        end
        if (i_cmd.save_vgr) begin
            r_vgr <= r_prod[14:0];
        end
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_cmd.load_item) begin
            r_active <= act;
        end
    end

    // shared multiplier operands
    always_comb begin
        case (i_cmd.mul_sel)
            MUL_VOL_GL: begin
                mul_a = $signed({9'd0, r_vol});
                mul_b = $signed({8'd0, r_gl});
            end
            MUL_VOL_GR: begin
                mul_a = $signed({9'd0, r_vol});
                mul_b = $signed({8'd0, r_gr});
            end
            MUL_SMP_L: begin
                mul_a = 17'(r_left);
                mul_b = $signed({1'b0, r_vgl});
            end
            default: begin
                mul_a = 17'(r_rs);
                mul_b = $signed({1'b0, r_vgr});
            end
        endcase
    end

    // round half up, then floor shift by 13
    assign rnd     = r_prod + 33'sd4096;
    assign contrib = $signed(rnd[30:13]);

    always_comb begin
        acc_in  = i_cmd.acc_left ? (ACC_W+1)'(r_left_sum) : (ACC_W+1)'(r_right_sum);
        acc_sum = acc_in + (ACC_W+1)'(contrib);
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_sat = acc_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    always_comb begin
        l_clip = (r_left_sum > OUT_MAX) || (r_left_sum < OUT_MIN);
        r_clip = (r_right_sum > OUT_MAX) || (r_right_sum < OUT_MIN);
        if (r_left_sum > OUT_MAX) begin
            l_sat = 16'sh7fff;
        end else if (r_left_sum < OUT_MIN) begin
            l_sat = -16'sh8000;
        end else begin
            l_sat = r_left_sum[SMP_W-1:0];
        end
        if (r_right_sum > OUT_MAX) begin
            r_sat = 16'sh7fff;
        end else if (r_right_sum < OUT_MIN) begin
            r_sat = -16'sh8000;
        end else begin
            r_sat = r_right_sum[SMP_W-1:0];
        end
    end

    always_comb begin
        n_left_sum  = r_left_sum;
        n_right_sum = r_right_sum;
        if (i_cmd.acc_left && r_active) begin
            n_left_sum = acc_sat;
        end
        if (i_cmd.acc_right && r_active) begin
            n_right_sum = acc_sat;
        end
        if (i_cmd.emit) begin
            n_left_sum  = '0;
            n_right_sum = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_sum  <= '0;
            r_right_sum <= '0;
        end else begin
            r_left_sum  <= n_left_sum;
            r_right_sum <= n_right_sum;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_left_out  <= l_sat;
            r_right_out <= r_sat;
            r_clipped   <= l_clip || r_clip;
        end
    end

    assign o_status.frame_end = r_end;
    assign o_status.out_free  = out_free;
    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_left_out;
    assign o_right_out = r_right_out;
    assign o_clipped   = r_clipped;

endmodule

>>> rtl/stereo_channel_pan_mixer_core.sv
// Top level of the stereo channel pan mixer: register block, sequencer, datapath.
// Depends on scpm_pkg, scpm_regs, scpm_ctrl and scpm_dp.

// Each transfer on the input carries one channel's sample pair; enabled, unmuted
// channels are scaled by volume (Q1.7) and linear pan gain (Q2.6) and summed into
// 24-bit saturating accumulators, and the transfer marked frame_end releases one
// stereo result saturated to 16 bits with a clip flag. The single shared multiplier
// forms volume*gain for each side and then sample*(volume*gain) for each side, one
// product a cycle, followed by one accumulate step; o_stall holds off the next
// transfer until the item is through. A frame end adds a step that loads the
// output register, which waits while the sink holds the last result with i_stall.
// Registers sit at byte address 8*index on the 64-bit configuration port and must
// be written only while the block is idle.
module stereo_channel_pan_mixer_core
    import scpm_pkg::*;
#(
    parameter int NUM_CHANNELS = SCPM_NUM_CHANNELS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_ADDR_W-1:0]   paddr,
    input  logic [CFG_DATA_W-1:0]   pwdata,
    output logic [CFG_DATA_W-1:0]   prdata,
    output logic                    pready,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [CHAN_W-1:0]       i_chan_index,
    input  logic signed [SMP_W-1:0] i_left_in,
    input  logic signed [SMP_W-1:0] i_right_in,
    input  logic                    i_frame_end,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SMP_W-1:0] o_left_out,
    output logic signed [SMP_W-1:0] o_right_out,
    output logic                    o_clipped
);

    t_cfg       cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    assign pready = 1'b1;

    scpm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    scpm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    scpm_dp #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_chan_index (i_chan_index),
        .i_left_in    (i_left_in),
        .i_right_in   (i_right_in),
        .i_frame_end  (i_frame_end),
        .i_out_stall  (i_stall),
        .o_out_valid  (o_valid),
        .o_left_out   (o_left_out),
        .o_right_out  (o_right_out),
        .o_clipped    (o_clipped)
    );

`ifndef SYNTH
    // one item at a time: an accepted transfer blocks the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted in the cycle after a transfer");

    // a clip flag only comes with a value pinned at a 16-bit bound
    a_clip_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clipped) |->
            (o_left_out == 16'sh7fff || o_left_out == -16'sh8000 ||
             o_right_out == 16'sh7fff || o_right_out == -16'sh8000))
        else $error("clip flag set on an unsaturated result");
`endif

endmodule

>>> tb/scpm_mix_checker.sv
`timescale 1ns / 100ps
// Checker for the stereo channel pan mixer: watches the register port and both
// sample channels, predicts every mixed frame and compares it with the output.
// Depends on scpm_pkg.
module scpm_mix_checker
    import scpm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [CFG_ADDR_W-1:0]   paddr,
    input  logic [CFG_DATA_W-1:0]   pwdata,
    input  logic                    pready,
    input  logic                    i_valid,
    input  logic                    o_stall,
    input  logic [CHAN_W-1:0]       i_chan_index,
    input  logic signed [SMP_W-1:0] i_left_in,
    input  logic signed [SMP_W-1:0] i_right_in,
    input  logic                    i_frame_end,
    input  logic                    o_valid,
    input  logic                    i_stall,
    input  logic signed [SMP_W-1:0] o_left_out,
    input  logic signed [SMP_W-1:0] o_right_out,
    input  logic                    o_clipped,
    output int                      o_mismatches,
    output int                      o_pending,
    output int                      o_results
);

    localparam int ACC_HI = (1 << (ACC_W - 1)) - 1;
    localparam int ACC_LO = -(1 << (ACC_W - 1));

    typedef struct packed {
        logic signed [SMP_W-1:0] left;
        logic signed [SMP_W-1:0] right;
        logic                    clip;
    } t_mix_frame;

    t_mix_frame expected_mix_q[$];

    // shadow copy of the register block
    logic [63:0] vol_reg;
    logic [63:0] pan_reg;
    logic [7:0]  en_reg;
    logic [7:0]  mute_reg;
    logic [7:0]  st_reg;

    logic signed [ACC_W-1:0] left_acc;
    logic signed [ACC_W-1:0] right_acc;

    // sample * volume * gain, Q.13 rounded half up
    function automatic int pan_scale(input int smp, input int vol, input int gain);
        longint prod;
        prod = longint'(smp) * longint'(vol) * longint'(gain) + 64'sd4096;
        return int'(prod >>> 13);
    endfunction

    function automatic logic signed [ACC_W-1:0] acc_add(input logic signed [ACC_W-1:0] acc,
                                                        input int contrib);
        int s;
        s = int'(acc) + contrib;
        if (s > ACC_HI) s = ACC_HI;
        if (s < ACC_LO) s = ACC_LO;
        return ACC_W'(s);
    endfunction

    function automatic logic signed [SMP_W-1:0] clamp16(input int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return SMP_W'(v);
    endfunction

    task automatic apply_reg_write();
        case (paddr[CFG_ADDR_W-1:3])
            REG_VOLUMES: vol_reg = pwdata;
            REG_PANS:    pan_reg = pwdata;
            REG_ENABLE:  en_reg = pwdata[7:0];
            REG_MUTE:    mute_reg = pwdata[7:0];
            REG_STEREO:  st_reg = pwdata[7:0];
            default: ;
        endcase
    endtask

    task automatic mix_channel(input logic [CHAN_W-1:0] ch, input logic signed [SMP_W-1:0] l,
                               input logic signed [SMP_W-1:0] r, input logic fe);
        int vol;
        int pan;
        int right_src;
        int lsum;
        int rsum;
        t_mix_frame res;
        if (int'(ch) < SCPM_NUM_CHANNELS && en_reg[ch] && !mute_reg[ch]) begin
            vol = int'(vol_reg[8*ch +: 8]);
            pan = int'($signed(pan_reg[8*ch +: 8]));
            right_src = st_reg[ch] ? int'(r) : int'(l);
            if (vol > 128) vol = 128;
            if (pan > 64) pan = 64;
            if (pan < -64) pan = -64;
            left_acc = acc_add(left_acc, pan_scale(int'(l), vol, 64 - pan));
            right_acc = acc_add(right_acc, pan_scale(right_src, vol, 64 + pan));
        end
        if (fe) begin
            lsum = int'(left_acc);
            rsum = int'(right_acc);
            res.left = clamp16(lsum);
            res.right = clamp16(rsum);
            res.clip = (lsum > 32767) || (lsum < -32768) || (rsum > 32767) || (rsum < -32768);
            expected_mix_q.push_back(res);
            left_acc = '0;
            right_acc = '0;
        end
    endtask

    task automatic check_mix();
        t_mix_frame want;
        if (expected_mix_q.size() == 0) begin
            if (o_mismatches < 10)
                $display("unexpected mix result L=%0d R=%0d clip=%0b",
                         o_left_out, o_right_out, o_clipped);
            o_mismatches++;
            return;
        end
        want = expected_mix_q.pop_front();
        o_results++;
        if (o_left_out !== want.left || o_right_out !== want.right ||
            o_clipped !== want.clip) begin
            if (o_mismatches < 10)
                $display("mix mismatch: expected L=%0d R=%0d clip=%0b, got L=%0d R=%0d clip=%0b",
                         want.left, want.right, want.clip,
                         o_left_out, o_right_out, o_clipped);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            vol_reg = VOLUMES_RESET;
            pan_reg = '0;
            en_reg = '0;
            mute_reg = '0;
            st_reg = '0;
            left_acc = '0;
            right_acc = '0;
            o_mismatches = 0;
            o_results = 0;
            expected_mix_q.delete();
        end else begin
            // retire the output first: a frame accepted now cannot complete this edge
            if (o_valid && !i_stall) check_mix();
            if (psel && penable && pwrite && pready) apply_reg_write();
            if (i_valid && !o_stall) mix_channel(i_chan_index, i_left_in, i_right_in, i_frame_end);
        end
        o_pending = expected_mix_q.size();
    end

endmodule

>>> tb/tb_stereo_channel_pan_mixer_core.sv
`timescale 1ns / 100ps
// Top of the stereo channel pan mixer testbench: clock, reset, register writes,
// sample stimulus with random gaps and output stalls, and the verdict.
// Depends on scpm_pkg, stereo_channel_pan_mixer_core and scpm_mix_checker.
module tb_stereo_channel_pan_mixer_core;
    import scpm_pkg::*;

    localparam int ITEM_TARGET = 1300;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CFG_ADDR_W-1:0]   paddr;
    logic [CFG_DATA_W-1:0]   pwdata;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    i_valid;
    logic                    o_stall;
    logic [CHAN_W-1:0]       i_chan_index;
    logic signed [SMP_W-1:0] i_left_in;
    logic signed [SMP_W-1:0] i_right_in;
    logic                    i_frame_end;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [SMP_W-1:0] o_left_out;
    logic signed [SMP_W-1:0] o_right_out;
    logic                    o_clipped;

    int mismatch_count;
    int pending_mixes;
    int results_seen;
    int items_sent;
    logic quiet_src;
    logic quiet_sink;

    stereo_channel_pan_mixer_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_chan_index (i_chan_index),
        .i_left_in    (i_left_in),
        .i_right_in   (i_right_in),
        .i_frame_end  (i_frame_end),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_left_out   (o_left_out),
        .o_right_out  (o_right_out),
        .o_clipped    (o_clipped)
    );

    scpm_mix_checker mix_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_chan_index (i_chan_index),
        .i_left_in    (i_left_in),
        .i_right_in   (i_right_in),
        .i_frame_end  (i_frame_end),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_left_out   (o_left_out),
        .o_right_out  (o_right_out),
        .o_clipped    (o_clipped),
        .o_mismatches (mismatch_count),
        .o_pending    (pending_mixes),
        .o_results    (results_seen)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int source_gap();
        return quiet_src ? 0 : int'($urandom_range(0, 10));
    endfunction

    function automatic int sink_gap();
        return quiet_sink ? 0 : int'($urandom_range(0, 10));
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic push_sample(input logic [2:0] ch, input logic [15:0] l, input logic [15:0] r,
                               input logic fe);
        int gap;
        gap = source_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid = 1'b1;
        i_chan_index = ch;
        i_left_in = l;
        i_right_in = r;
        i_frame_end = fe;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // drop valid, drain every frame, then give a non-final item time to finish
    task automatic settle_idle();
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (pending_mixes == 0);
        repeat (16) @(negedge i_clk);
    endtask

    // sink: after each transfer, stall for a freshly drawn number of cycles
    initial begin : sink
        int wait_n;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                wait_n = sink_gap();
                @(negedge i_clk);
                if (wait_n > 0) begin
                    i_stall = 1'b1;
                    repeat (wait_n) @(negedge i_clk);
                    i_stall = 1'b0;
                end
            end
        end
    end

    initial begin : watchdog
        #3_000_000;
        $display("stereo_channel_pan_mixer_core regression: fail");
        $finish;
    end

    initial begin : stimulus
        int phase;
        int quota;
        int kind;
        int n;
        logic [63:0] vols;
        logic [63:0] pans;
        logic [7:0] en;
        logic [7:0] mu;
        logic [7:0] st;

        items_sent = 0;
        quiet_src = 1'b0;
        quiet_sink = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_valid = 1'b0;
        i_chan_index = '0;
        i_left_in = '0;
        i_right_in = '0;
        i_frame_end = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings: every channel disabled, so the frame mixes to silence
        push_sample(3'd0, 16'h7FFF, 16'h8000, 1'b0);
        push_sample(3'd5, 16'h8000, 16'h7FFF, 1'b1);
        settle_idle();

        // ch0 center, ch1 full right, ch2 full left, ch3/ch4 pans beyond range,
        // ch5 muted, ch6 volume above range, ch7 silent; ch4..ch7 mono
        write_reg(REG_VOLUMES, 64'h00FF_8080_8080_8080);
        write_reg(REG_PANS, 64'hE000_2080_7FC0_4000);
        write_reg(REG_ENABLE, 64'hFFFF_FFFF_FFFF_FF00 | 64'hFF);
        write_reg(REG_MUTE, 64'hA5A5_0000_1234_5620);
        write_reg(REG_STEREO, 64'h0000_0000_0000_000F);
        for (int k = REG_STEREO + 1; k < 8; k++) write_reg(3'(k), {$urandom, $urandom});

        push_sample(3'd0, 16'h7FFF, 16'h7FFF, 1'b1);
        push_sample(3'd0, 16'h7FFF, 16'h7FFF, 1'b0);
        push_sample(3'd1, 16'h7FFF, 16'h8000, 1'b1);
        push_sample(3'd2, 16'h8000, 16'h8000, 1'b1);
        push_sample(3'd3, 16'd12345, -16'sd12345, 1'b0);
        push_sample(3'd4, 16'hFFFF, 16'd5, 1'b1);
        push_sample(3'd5, 16'd30000, -16'sd30000, 1'b1);
        push_sample(3'd6, 16'd1000, -16'sd1000, 1'b0);
        push_sample(3'd7, 16'h7FFF, 16'h7FFF, 1'b1);
        // rounding around zero
        push_sample(3'd0, 16'h0001, 16'hFFFF, 1'b1);
        push_sample(3'd0, 16'hFFFF, 16'h0001, 1'b1);
        push_sample(3'd1, 16'h0001, 16'h0001, 1'b1);
        for (int k = 0; k < 8; k++) push_sample(3'(k), pick_sample(), pick_sample(), k == 7);
        push_sample(3'd3, 16'h0000, 16'h0000, 1'b1);

        // drive both accumulators into their 24-bit limits within one frame
        for (int k = 0; k < 260; k++) begin
            if (k % 2 == 0) push_sample(3'd1, 16'h7FFF, 16'h7FFF, 1'b0);
            else push_sample(3'd2, 16'h8000, 16'h8000, k == 259);
        end

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            settle_idle();
            case (phase)
                0: begin vols = '0; pans = '0; en = 8'hFF; mu = 8'h00; st = 8'hFF; end
                1: begin vols = '1; pans = {8{8'h7F}}; en = 8'hFF; mu = 8'h00; st = 8'h00; end
                2: begin vols = VOLUMES_RESET; pans = {8{8'h80}}; en = 8'hFF; mu = 8'h00;
                         st = 8'hFF; end
                3: begin vols = '1; pans = '1; en = 8'hFF; mu = 8'h0F; st = 8'hAA; end
                default: begin
                    for (int k = 0; k < 8; k++) begin
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4, 5, 6: vols[8*k +: 8] = 8'($urandom_range(0, 128));
                            7: vols[8*k +: 8] = 8'd128;
                            default: vols[8*k +: 8] = 8'($urandom_range(129, 255));
                        endcase
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3, 4, 5, 6:
                                pans[8*k +: 8] = 8'(int'($urandom_range(0, 128)) - 64);
                            7: pans[8*k +: 8] = $urandom_range(0, 1) ? 8'h40 : 8'hC0;
                            default: pans[8*k +: 8] = 8'($urandom);
                        endcase
                    end
                    en = 8'($urandom | $urandom);
                    mu = 8'($urandom & $urandom & $urandom);
                    st = 8'($urandom);
                end
            endcase
            write_reg(REG_VOLUMES, vols);
            write_reg(REG_PANS, pans);
            write_reg(REG_ENABLE, {$urandom, 24'($urandom), en});
            write_reg(REG_MUTE, {$urandom, 24'($urandom), mu});
            write_reg(REG_STEREO, {$urandom, 24'($urandom), st});
            quiet_src = ($urandom_range(0, 3) == 0);
            quiet_sink = ($urandom_range(0, 3) == 0);

            quota = items_sent + int'($urandom_range(30, 90));
            while (items_sent < quota) begin
                kind = $urandom_range(0, 9);
                if (kind < 7) begin
                    // ordered frame over the first n channels
                    n = $urandom_range(1, 8);
                    for (int k = 0; k < n; k++)
                        push_sample(3'(k), pick_sample(), pick_sample(), k == n - 1);
                end else if (kind < 9) begin
                    n = $urandom_range(1, 12);
                    for (int k = 0; k < n; k++)
                        push_sample(3'($urandom), pick_sample(), pick_sample(), k == n - 1);
                end else begin
                    // loose items, frame ends scattered at random
                    n = $urandom_range(1, 6);
                    for (int k = 0; k < n; k++)
                        push_sample(3'($urandom), pick_sample(), pick_sample(),
                                    $urandom_range(0, 3) == 0);
                end
            end
            phase++;
        end

        @(negedge i_clk);
        i_valid = 1'b0;
        wait (pending_mixes == 0);
        repeat (20) @(posedge i_clk);

        $display("covered %0d sample transfers and %0d checked frames over %0d settings",
                 items_sent, results_seen, phase + 2);
        $display("including clamped volume and pan, mute, mono, and saturated accumulators");
        if (mismatch_count == 0 && pending_mixes == 0)
            $display("stereo_channel_pan_mixer_core regression: pass");
        else
            $display("stereo_channel_pan_mixer_core regression: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/scpm_pkg.sv
rtl/scpm_regs.sv
rtl/scpm_ctrl.sv
rtl/scpm_dp.sv
rtl/stereo_channel_pan_mixer_core.sv
tb/scpm_mix_checker.sv
tb/tb_stereo_channel_pan_mixer_core.sv
